>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPPM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define TPPM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/tppm_pkg.sv
// ----------------------------------------------------------------------------
// tppm_pkg
// Shared widths, payload types and control codes of the three-phase meter.
// ----------------------------------------------------------------------------
package tppm_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int OFF_W           = 8;
  localparam int OPD_W           = 13;  // sample minus offset
  localparam int SQ_BASE_W       = 23;  // bits of the largest single square
  localparam int SPP_W           = 9;
  localparam int CFG_DATA_W      = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int PHASES          = 3;
  localparam int RMS_W           = 12;
  localparam int REAL_W          = 24;
  localparam int APP_W           = 23;
  localparam int MAX_SAMPLES_DEF = 256;

  localparam logic [SPP_W-1:0] SPP_RESET = 9'd64;

  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_FIRST = 2'd0;
  localparam phase_t PHASE_LAST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPP  = 2'd0,
    REG_VOFF = 2'd1,
    REG_IOFF = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_t;

  typedef enum logic [1:0] {
    KIND_UU = 2'd0,
    KIND_II = 2'd1,
    KIND_UI = 2'd2
  } prod_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] volt_a;
    logic signed [SAMPLE_W-1:0] volt_b;
    logic signed [SAMPLE_W-1:0] volt_c;
    logic signed [SAMPLE_W-1:0] amp_a;
    logic signed [SAMPLE_W-1:0] amp_b;
    logic signed [SAMPLE_W-1:0] amp_c;
  } sample_t;

  typedef struct packed {
    phase_t                   phase;
    logic [RMS_W-1:0]         rms_voltage;
    logic [RMS_W-1:0]         rms_current;
    logic signed [REAL_W-1:0] real_power;
    logic [APP_W-1:0]         apparent_power;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> src/tppm_stream_if.sv
// ----------------------------------------------------------------------------
// tppm_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tppm_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> src/tppm_arith.sv
// ----------------------------------------------------------------------------
// tppm_arith
// Iterative divide-by-period and floor square root, one bit per cycle,
// both running through one shared subtractor.
// ----------------------------------------------------------------------------
module tppm_arith #(
  parameter int AW  = 62,
  parameter int DVW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tppm_pkg::arith_req_t      req,
  input  logic [AW-1:0]             operand,
  input  logic [tppm_pkg::SPP_W-1:0] divisor,
  output tppm_pkg::unit_stat_t      stat,
  output logic [AW-1:0]             result
);
  import tppm_pkg::*;

  localparam int SQ_STEPS  = AW / 2;
  localparam int MAX_STEPS = (DVW > SQ_STEPS) ? DVW : SQ_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  logic              busy;
  logic              done;
  arith_op_t         op;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  last_cnt;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     root;
  logic [AW-1:0]     mask;
  logic [SPP_W-1:0]  rem;
  logic [SPP_W:0]    trial;
  logic [AW:0]       opa;
  logic [AW:0]       opb;
  logic [AW:0]       diff;
  logic              ge;

  always_comb begin
    trial = {rem, acc[DVW-1]};
    unique case (op)
      OP_DIV: begin
        opa      = (AW+1)'(trial);
        opb      = (AW+1)'(divisor);
        last_cnt = CNT_W'(DVW - 1);
      end
      OP_SQRT: begin
        // root and mask never share a set bit, so OR stands in for the add
        opa      = {1'b0, acc};
        opb      = {1'b0, root | mask};
        last_cnt = CNT_W'(SQ_STEPS - 1);
      end
    endcase
    diff = opa - opb;
    ge   = !diff[AW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        acc  <= operand;
        root <= '0;
        mask <= {2'b01, {(AW-2){1'b0}}};
        rem  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        unique case (op)
          OP_DIV: begin
            rem <= ge ? diff[SPP_W-1:0] : trial[SPP_W-1:0];
            acc <= {acc[AW-2:0], ge};
          end
          OP_SQRT: begin
            if (ge) begin
              acc  <= diff[AW-1:0];
              root <= (root >> 1) | mask;
            end else begin
              root <= root >> 1;
            end
            mask <= mask >> 2;
          end
        endcase
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result    = (op == OP_DIV) ? AW'(acc[DVW-1:0]) : root;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> src/tppm_accum.sv
// ----------------------------------------------------------------------------
// tppm_accum
// Per-phase sums of u*u, i*i and u*i, fed by one shared 13x13 multiplier
// stepping through the nine products of a sample set.
// ----------------------------------------------------------------------------
module tppm_accum #(
  parameter int SQ_W = 31,
  parameter int PS_W = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  tppm_pkg::sample_t                   sample,
  input  logic signed [tppm_pkg::OFF_W-1:0]   voff,
  input  logic signed [tppm_pkg::OFF_W-1:0]   ioff,
  input  logic                                clear,
  input  tppm_pkg::phase_t                    rd_phase,
  output tppm_pkg::unit_stat_t                stat,
  output logic [SQ_W-1:0]                     vsum,
  output logic [SQ_W-1:0]                     asum,
  output logic signed [PS_W-1:0]              psum
);
  import tppm_pkg::*;

  localparam int MUL_W = 2 * OPD_W;

  logic signed [OPD_W-1:0] u_smp [PHASES];
  logic signed [OPD_W-1:0] i_smp [PHASES];
  logic                    issuing;
  phase_t                  iss_phase;
  prod_kind_t              iss_kind;
  logic signed [OPD_W-1:0] mul_a;
  logic signed [OPD_W-1:0] mul_b;
  logic signed [MUL_W-1:0] prod;
  logic                    acc_valid;
  phase_t                  acc_phase;
  prod_kind_t              acc_kind;
  logic                    acc_last;
  logic                    done;
  logic [SQ_W-1:0]         vsq [PHASES];
  logic [SQ_W-1:0]         asq [PHASES];
  logic signed [PS_W-1:0]  psm [PHASES];
  phase_t                  sum_addr;

  assign mul_a = (iss_kind == KIND_II) ? i_smp[iss_phase] : u_smp[iss_phase];
  assign mul_b = (iss_kind == KIND_UU) ? u_smp[iss_phase] : i_smp[iss_phase];

  // one read port: the accumulate stage owns it while acc_valid is high
  assign sum_addr = acc_valid ? acc_phase : rd_phase;
  assign vsum     = vsq[sum_addr];
  assign asum     = asq[sum_addr];
  assign psum     = psm[sum_addr];

  always_ff @(posedge clk) begin
    if (load) begin
      u_smp[0] <= OPD_W'(sample.volt_a) - OPD_W'(voff);
      u_smp[1] <= OPD_W'(sample.volt_b) - OPD_W'(voff);
      u_smp[2] <= OPD_W'(sample.volt_c) - OPD_W'(voff);
      i_smp[0] <= OPD_W'(sample.amp_a) - OPD_W'(ioff);
      i_smp[1] <= OPD_W'(sample.amp_b) - OPD_W'(ioff);
      i_smp[2] <= OPD_W'(sample.amp_c) - OPD_W'(ioff);
    end
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      iss_phase <= PHASE_FIRST;
      iss_kind  <= KIND_UU;
      acc_valid <= 1'b0;
      acc_phase <= PHASE_FIRST;
      acc_kind  <= KIND_UU;
      acc_last  <= 1'b0;
      done      <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
        vsq[p] <= '0;
        asq[p] <= '0;
        psm[p] <= '0;
      end
    end else begin
      done      <= acc_valid && acc_last;
      acc_valid <= issuing;
      acc_phase <= iss_phase;
      acc_kind  <= iss_kind;
      acc_last  <= (iss_phase == PHASE_LAST) && (iss_kind == KIND_UI);

      if (load) begin
        issuing   <= 1'b1;
        iss_phase <= PHASE_FIRST;
        iss_kind  <= KIND_UU;
      end else if (issuing) begin
        unique case (iss_kind)
          KIND_UU: iss_kind <= KIND_II;
          KIND_II: iss_kind <= KIND_UI;
          KIND_UI: begin
            iss_kind <= KIND_UU;
            if (iss_phase == PHASE_LAST) begin
              issuing <= 1'b0;
            end else begin
              iss_phase <= iss_phase + 1'b1;
            end
          end
          default: issuing <= 1'b0;
        endcase
      end

      if (clear) begin
        for (int p = 0; p < PHASES; p++) begin
          vsq[p] <= '0;
          asq[p] <= '0;
          psm[p] <= '0;
        end
      end else if (acc_valid) begin
        unique case (acc_kind)
          KIND_UU: vsq[acc_phase] <= vsum + SQ_W'($unsigned(prod));
          KIND_II: asq[acc_phase] <= asum + SQ_W'($unsigned(prod));
          KIND_UI: psm[acc_phase] <= psum + PS_W'(prod);
          default: ;
        endcase
      end
    end
  end

  assign stat.busy = issuing || acc_valid;
  assign stat.done = done;

endmodule

>>> src/three_phase_power_meter_unit.sv
// ----------------------------------------------------------------------------
// three_phase_power_meter_unit
// Sample set: the nine products go through one shared multiplier and one
// accumulate stage; then the count is updated and input is ready again,
// unless the count reaches the period length. Period end: per phase four
// divides and three square roots on the shared unit, plus the multiply and
// emit states. Input is not ready until the third result.
// Synchronous reset clears the sums, the count and the registers to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_phase_power_meter_unit #(
  parameter int MAX_SAMPLES = tppm_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tppm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tppm_pkg::CFG_DATA_W-1:0]  cfg_data,
  tppm_stream_if.sink                      samples,
  tppm_stream_if.source                    results
);
  import tppm_pkg::*;

  localparam int SQ_W = SQ_BASE_W + $clog2(MAX_SAMPLES);
  localparam int PS_W = SQ_W + 1;
  localparam int AW   = 2 * SQ_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_ACCUM  = 11'b000_0000_0010,
    ST_DIV_V  = 11'b000_0000_0100,
    ST_SQRT_V = 11'b000_0000_1000,
    ST_DIV_A  = 11'b000_0001_0000,
    ST_SQRT_A = 11'b000_0010_0000,
    ST_DIV_P  = 11'b000_0100_0000,
    ST_MUL    = 11'b000_1000_0000,
    ST_SQRT_S = 11'b001_0000_0000,
    ST_DIV_S  = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t                   state;
  logic [SPP_W-1:0]         spp;
  logic signed [OFF_W-1:0]  voff;
  logic signed [OFF_W-1:0]  ioff;
  logic [SPP_W-1:0]         item_count;
  logic [SPP_W-1:0]         count_next;
  phase_t                   phase_idx;
  logic                     issued;
  logic [AW-1:0]            work;
  logic [RMS_W-1:0]         res_vrms;
  logic [RMS_W-1:0]         res_irms;
  logic signed [REAL_W-1:0] res_real;
  logic [APP_W-1:0]         res_app;
  logic [REAL_W-1:0]        q_real;
  result_t                  out_data;
  logic                     out_valid;
  logic                     emit_go;
  logic                     is_compute;
  logic                     acc_load;
  logic                     acc_clear;
  unit_stat_t               acc_stat;
  unit_stat_t               arith_stat;
  arith_req_t               arith_req;
  logic [AW-1:0]            operand;
  logic [AW-1:0]            arith_result;
  logic [SQ_W-1:0]          vsum;
  logic [SQ_W-1:0]          asum;
  logic signed [PS_W-1:0]   psum;
  logic [PS_W-1:0]          pmag;
  logic [AW-1:0]            sq_prod;

  tppm_accum #(
    .SQ_W (SQ_W),
    .PS_W (PS_W)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .load     (acc_load),
    .sample   (samples.data),
    .voff     (voff),
    .ioff     (ioff),
    .clear    (acc_clear),
    .rd_phase (phase_idx),
    .stat     (acc_stat),
    .vsum     (vsum),
    .asum     (asum),
    .psum     (psum)
  );

  tppm_arith #(
    .AW  (AW),
    .DVW (PS_W)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .req     (arith_req),
    .operand (operand),
    .divisor (spp),
    .stat    (arith_stat),
    .result  (arith_result)
  );

  assign samples.ready = (state == ST_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign acc_load   = samples.valid && samples.ready;
  assign emit_go    = !out_valid || results.ready;
  assign acc_clear  = (state == ST_EMIT) && emit_go && (phase_idx == PHASE_LAST);
  assign count_next = item_count + 1'b1;
  assign pmag       = psum[PS_W-1] ? (~psum + 1'b1) : psum;
  assign sq_prod    = vsum * asum;
  assign q_real     = arith_result[REAL_W-1:0];

  always_comb begin
    is_compute   = 1'b1;
    arith_req.op = OP_DIV;
    operand      = '0;
    unique case (state)
      ST_DIV_V:  operand = AW'(vsum);
      ST_SQRT_V: begin
        arith_req.op = OP_SQRT;
        operand      = work;
      end
      ST_DIV_A:  operand = AW'(asum);
      ST_SQRT_A: begin
        arith_req.op = OP_SQRT;
        operand      = work;
      end
      ST_DIV_P:  operand = AW'(pmag);
      ST_SQRT_S: begin
        arith_req.op = OP_SQRT;
        operand      = work;
      end
      ST_DIV_S:  operand = work;
      default:   is_compute = 1'b0;
    endcase
    arith_req.start = is_compute && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      spp        <= SPP_RESET;
      voff       <= '0;
      ioff       <= '0;
      item_count <= '0;
      phase_idx  <= PHASE_FIRST;
      issued     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPP: begin
            // out-of-range period lengths are dropped
            if ((cfg_data != '0) && (int'(cfg_data) <= MAX_SAMPLES)) begin
              spp <= cfg_data;
            end
          end
          REG_VOFF: voff <= cfg_data[OFF_W-1:0];
          REG_IOFF: ioff <= cfg_data[OFF_W-1:0];
          default:  ;
        endcase
      end

      if (arith_stat.done) begin
        issued <= 1'b0;
      end else if (arith_req.start) begin
        issued <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (acc_stat.done) begin
            item_count <= count_next;
            state      <= (count_next >= spp) ? ST_DIV_V : ST_IDLE;
          end
        end
        ST_DIV_V: begin
          if (arith_stat.done) begin
            work  <= arith_result;
            state <= ST_SQRT_V;
          end
        end
        ST_SQRT_V: begin
          if (arith_stat.done) begin
            res_vrms <= arith_result[RMS_W-1:0];
            state    <= ST_DIV_A;
          end
        end
        ST_DIV_A: begin
          if (arith_stat.done) begin
            work  <= arith_result;
            state <= ST_SQRT_A;
          end
        end
        ST_SQRT_A: begin
          if (arith_stat.done) begin
            res_irms <= arith_result[RMS_W-1:0];
            state    <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (arith_stat.done) begin
            // magnitude was divided; restore the sign (truncation toward zero)
            res_real <= psum[PS_W-1] ? (~q_real + 1'b1) : q_real;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          work  <= sq_prod;
          state <= ST_SQRT_S;
        end
        ST_SQRT_S: begin
          if (arith_stat.done) begin
            work  <= arith_result;
            state <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          if (arith_stat.done) begin
            res_app <= arith_result[APP_W-1:0];
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_data.phase          <= phase_idx;
            out_data.rms_voltage    <= res_vrms;
            out_data.rms_current    <= res_irms;
            out_data.real_power     <= res_real;
            out_data.apparent_power <= res_app;
            out_data.last           <= (phase_idx == PHASE_LAST);
            out_valid               <= 1'b1;
            if (phase_idx == PHASE_LAST) begin
              phase_idx  <= PHASE_FIRST;
              item_count <= '0;
              state      <= ST_IDLE;
            end else begin
              phase_idx <= phase_idx + 1'b1;
              state     <= ST_DIV_V;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TPPM_ASSERT_IMP(a_ready_units_idle, samples.ready, !acc_stat.busy && !arith_stat.busy, "input ready while a unit is busy")
  `TPPM_ASSERT_NEXT(a_transfer_starts_accum, samples.valid && samples.ready, acc_stat.busy, "sample transfer did not start accumulation")
  `TPPM_ASSERT_IMP(a_start_unit_free, arith_req.start, !arith_stat.busy, "arith start while busy")
  `TPPM_ASSERT_IMP(a_clear_quiet, acc_clear, !acc_stat.busy && !samples.ready, "sum clear during accumulation")

endmodule
